// ----- src/sfws_pkg.sv -----
// Shared types and constants for the SPI flash write sequencer.
package sfws_pkg;

    localparam int ADDR_W = 24;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;

    // SPI flash opcodes
    localparam logic [BYTE_W-1:0] OP_BYTE_PROG = 8'h02;
    localparam logic [BYTE_W-1:0] OP_WRDI      = 8'h04;
    localparam logic [BYTE_W-1:0] OP_WREN      = 8'h06;
    localparam logic [BYTE_W-1:0] OP_EBSY      = 8'h70;
    localparam logic [BYTE_W-1:0] OP_DBSY      = 8'h80;
    localparam logic [BYTE_W-1:0] OP_AAI       = 8'hAD;

    // Wait marks after a frame
    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_BUSY = 2'd1;
    localparam logic [1:0] WAIT_MISO = 2'd2;

    // Request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Job kinds passed from the front to the back
    typedef logic [1:0] t_job_op;
    localparam t_job_op JOB_CLOSE     = 2'd0;
    localparam t_job_op JOB_SINGLE    = 2'd1;
    localparam t_job_op JOB_PAIR_OPEN = 2'd2;
    localparam t_job_op JOB_PAIR_CONT = 2'd3;

    typedef struct packed {
        t_job_op             op;
        logic                close_after;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   d0;
        logic [BYTE_W-1:0]   d1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ----- src/sfws_front.sv -----
// Front part: accepts requests, tracks the job and classifies each data word.
module sfws_front
    import sfws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_req_type,
    input  logic [ADDR_W-1:0]    i_start_address,
    input  logic [CNT_W-1:0]     i_byte_count,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_push,
    output t_job                 o_job
);

    logic                r_job_active, n_job_active;
    logic [ADDR_W-1:0]   r_next_address, n_next_address;
    logic [CNT_W-1:0]    r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]   r_pending_byte, n_pending_byte;
    logic                r_pending_valid, n_pending_valid;
    logic                r_word_open, n_word_open;

    logic [CNT_W-1:0]    left_after_pair;
    logic [CNT_W-1:0]    left_after_one;

    assign left_after_pair = r_bytes_left - CNT_W'(2);
    assign left_after_one  = r_bytes_left - CNT_W'(1);

    always_comb begin
        n_job_active    = r_job_active;
        n_next_address  = r_next_address;
        n_bytes_left    = r_bytes_left;
        n_pending_byte  = r_pending_byte;
        n_pending_valid = r_pending_valid;
        n_word_open     = r_word_open;
        o_push          = 1'b0;
        o_job.op          = JOB_CLOSE;
        o_job.close_after = 1'b0;
        o_job.addr        = r_next_address;
        o_job.d0          = r_pending_byte;
        o_job.d1          = i_data_byte;

        if (i_accept) begin
            if (i_req_type == REQ_START) begin
                // leave word mode before abandoning the old job
                o_push          = r_word_open;
                o_job.op        = JOB_CLOSE;
                n_word_open     = 1'b0;
                n_pending_valid = 1'b0;
                n_next_address  = i_start_address;
                n_bytes_left    = i_byte_count;
                n_job_active    = (i_byte_count != '0);
            end else if (r_job_active) begin
                if (r_pending_valid) begin
                    o_push            = 1'b1;
                    o_job.op          = r_word_open ? JOB_PAIR_CONT : JOB_PAIR_OPEN;
                    o_job.close_after = (left_after_pair < CNT_W'(2));
                    n_word_open       = !(left_after_pair < CNT_W'(2));
                    n_pending_valid   = 1'b0;
                    n_next_address    = r_next_address + ADDR_W'(2);
                    n_bytes_left      = left_after_pair;
                    n_job_active      = (left_after_pair != '0);
                end else if (!r_word_open &&
                             (r_next_address[0] || r_bytes_left < CNT_W'(2))) begin
                    o_push         = 1'b1;
                    o_job.op       = JOB_SINGLE;
                    n_next_address = r_next_address + ADDR_W'(1);
                    n_bytes_left   = left_after_one;
                    n_job_active   = (left_after_one != '0);
                end else begin
                    // hold the first byte of a pair
                    n_pending_byte  = i_data_byte;
                    n_pending_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_active    <= 1'b0;
            r_next_address  <= '0;
            r_bytes_left    <= '0;
            r_pending_valid <= 1'b0;
            r_word_open     <= 1'b0;
        end else begin
            r_job_active    <= n_job_active;
            r_next_address  <= n_next_address;
            r_bytes_left    <= n_bytes_left;
            r_pending_valid <= n_pending_valid;
            r_word_open     <= n_word_open;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pending_byte <= n_pending_byte;
    end

endmodule

// ----- src/sfws_queue.sv -----
// Two-entry job queue between the front and back parts.
module sfws_queue
    import sfws_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_job,
    output t_queue_status o_status
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- src/sfws_back.sv -----
// Back part: expands each queued job into SPI bytes, one per cycle unless stalled.
module sfws_back
    import sfws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_job                 i_job,
    input  t_queue_status        i_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_spi_byte,
    output logic                 o_frame_start,
    output logic                 o_frame_end,
    output logic [1:0]           o_wait_after,
    output logic                 o_last
);

    localparam logic [3:0] S_EBSY = 4'd0;
    localparam logic [3:0] S_WREN = 4'd1;
    localparam logic [3:0] S_AAI  = 4'd2;
    localparam logic [3:0] S_BP   = 4'd3;
    localparam logic [3:0] S_A2   = 4'd4;
    localparam logic [3:0] S_A1   = 4'd5;
    localparam logic [3:0] S_A0   = 4'd6;
    localparam logic [3:0] S_D0   = 4'd7;
    localparam logic [3:0] S_D1   = 4'd8;
    localparam logic [3:0] S_DS   = 4'd9;
    localparam logic [3:0] S_WRDI = 4'd10;
    localparam logic [3:0] S_DBSY = 4'd11;

    logic        r_busy;
    t_job        r_job;
    logic [3:0]  r_slot;
    logic [3:0]  next_slot;
    logic [3:0]  start_slot;
    logic        advance;
    logic        load;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_spi_byte;
    logic              r_frame_start;
    logic              r_frame_end;
    logic [1:0]        r_wait_after;
    logic              r_last;

    logic [BYTE_W-1:0] slot_byte;
    logic              slot_fs;
    logic              slot_fe;
    logic [1:0]        slot_wait;
    logic              slot_last;

    assign advance = r_busy && (!r_out_valid || i_out_ready);
    assign load    = !i_status.empty && (!r_busy || (advance && slot_last));
    assign o_pop   = load;

    always_comb begin
        unique case (i_job.op)
            JOB_CLOSE:     start_slot = S_WRDI;
            JOB_SINGLE:    start_slot = S_WREN;
            JOB_PAIR_OPEN: start_slot = S_EBSY;
            JOB_PAIR_CONT: start_slot = S_AAI;
            default:       start_slot = S_WRDI;
        endcase
    end

    always_comb begin
        slot_byte = OP_WREN;
        slot_fs   = 1'b0;
        slot_fe   = 1'b0;
        slot_wait = WAIT_NONE;
        slot_last = 1'b0;
        next_slot = r_slot;
        unique case (r_slot)
            S_EBSY: begin
                slot_byte = OP_EBSY;
                slot_fs   = 1'b1;
                slot_fe   = 1'b1;
                next_slot = S_WREN;
            end
            S_WREN: begin
                slot_byte = OP_WREN;
                slot_fs   = 1'b1;
                slot_fe   = 1'b1;
                next_slot = (r_job.op == JOB_SINGLE) ? S_BP : S_AAI;
            end
            S_AAI: begin
                slot_byte = OP_AAI;
                slot_fs   = 1'b1;
                next_slot = (r_job.op == JOB_PAIR_OPEN) ? S_A2 : S_D0;
            end
            S_BP: begin
                slot_byte = OP_BYTE_PROG;
                slot_fs   = 1'b1;
                next_slot = S_A2;
            end
            S_A2: begin
                slot_byte = r_job.addr[23:16];
                next_slot = S_A1;
            end
            S_A1: begin
                slot_byte = r_job.addr[15:8];
                next_slot = S_A0;
            end
            S_A0: begin
                slot_byte = r_job.addr[7:0];
                next_slot = (r_job.op == JOB_SINGLE) ? S_DS : S_D0;
            end
            S_D0: begin
                slot_byte = r_job.d0;
                next_slot = S_D1;
            end
            S_D1: begin
                slot_byte = r_job.d1;
                slot_fe   = 1'b1;
                slot_wait = WAIT_MISO;
                slot_last = !r_job.close_after;
                next_slot = S_WRDI;
            end
            S_DS: begin
                slot_byte = r_job.d1;
                slot_fe   = 1'b1;
                slot_wait = WAIT_BUSY;
                slot_last = 1'b1;
            end
            S_WRDI: begin
                slot_byte = OP_WRDI;
                slot_fs   = 1'b1;
                slot_fe   = 1'b1;
                next_slot = S_DBSY;
            end
            S_DBSY: begin
                slot_byte = OP_DBSY;
                slot_fs   = 1'b1;
                slot_fe   = 1'b1;
                slot_last = 1'b1;
            end
            default: begin
                slot_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= S_WRDI;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_slot <= start_slot;
            end else if (advance) begin
                r_busy <= !slot_last;
                r_slot <= next_slot;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (advance) begin
            r_spi_byte    <= slot_byte;
            r_frame_start <= slot_fs;
            r_frame_end   <= slot_fe;
            r_wait_after  <= slot_wait;
            r_last        <= slot_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_spi_byte    = r_spi_byte;
    assign o_frame_start = r_frame_start;
    assign o_frame_end   = r_frame_end;
    assign o_wait_after  = r_wait_after;
    assign o_last        = r_last;

endmodule

// ----- src/spi_flash_write_sequencer_unit.sv -----
// Top level of the SPI flash write sequencer: front, job queue and back part.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready    | request: type, address, count, data
//  out     | output    | o_out_valid / i_out_ready  | one SPI byte with frame and wait marks
//
// The front takes one request a cycle while the two-entry job queue has room.
// The back emits one SPI byte a cycle unless stalled; a job is 2 to 10 bytes by its kind
// (close, single byte, first or later pair, with or without a close after it);
// steady word programming gives 3 bytes per 2 data words.
// Reset is synchronous, active low, and clears job state, queue and output.
// A stalled output holds the back part; the front keeps accepting until the queue fills.
module spi_flash_write_sequencer_unit
    import sfws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [ADDR_W-1:0]    i_start_address,
    input  logic [CNT_W-1:0]     i_byte_count,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_spi_byte,
    output logic                 o_frame_start,
    output logic                 o_frame_end,
    output logic [1:0]           o_wait_after,
    output logic                 o_last
);

    logic          accept;
    logic          push;
    logic          pop;
    t_job          front_job;
    t_job          queue_job;
    t_queue_status queue_status;

    assign o_in_ready = !queue_status.full;
    assign accept     = i_in_valid && o_in_ready;

    sfws_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_req_type      (i_req_type),
        .i_start_address (i_start_address),
        .i_byte_count    (i_byte_count),
        .i_data_byte     (i_data_byte),
        .o_push          (push),
        .o_job           (front_job)
    );

    sfws_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (queue_job),
        .o_status (queue_status)
    );

    sfws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (queue_job),
        .i_status      (queue_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_spi_byte    (o_spi_byte),
        .o_frame_start (o_frame_start),
        .o_frame_end   (o_frame_end),
        .o_wait_after  (o_wait_after),
        .o_last        (o_last)
    );

endmodule

// ----- tb/spi_flash_write_sequencer_unit_tb.sv -----
// Self-checking testbench for the SPI flash write sequencer: predicted SPI bytes vs. DUT output.
module spi_flash_write_sequencer_unit_tb;
    import sfws_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic [BYTE_W-1:0] data;
    } t_flash_req;

    typedef struct packed {
        logic [BYTE_W-1:0] spi_byte;
        logic              frame_start;
        logic              frame_end;
        logic [1:0]        wait_mark;
        logic              last_of_item;
    } t_spi_rec;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_req_type = 1'b0;
    logic [ADDR_W-1:0] i_start_address = '0;
    logic [CNT_W-1:0]  i_byte_count = '0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BYTE_W-1:0] o_spi_byte;
    logic              o_frame_start;
    logic              o_frame_end;
    logic [1:0]        o_wait_after;
    logic              o_last;

    spi_flash_write_sequencer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_start_address(i_start_address),
        .i_byte_count   (i_byte_count),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_spi_byte     (o_spi_byte),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_wait_after   (o_wait_after),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Pending request words and expected SPI bytes
    t_flash_req req_q[$];
    t_spi_rec   spi_expect_q[$];
    t_spi_rec   item_frames[$];

    int mismatch_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_quiet = 0;
    int recv_quiet = 0;
    bit in_taken = 1'b0;

    // Predictor state
    bit                wr_active;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_left;
    logic [BYTE_W-1:0] held_byte;
    bit                held_valid;
    bit                aai_open;

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 100)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic emit(input logic [BYTE_W-1:0] b, input logic fs, input logic fe,
                        input logic [1:0] wm);
        t_spi_rec r;
        r.spi_byte     = b;
        r.frame_start  = fs;
        r.frame_end    = fe;
        r.wait_mark    = wm;
        r.last_of_item = 1'b0;
        item_frames.push_back(r);
    endtask

    task automatic emit_cmd(input logic [BYTE_W-1:0] op);
        emit(op, 1'b1, 1'b1, WAIT_NONE);
    endtask

    task automatic emit_addr(input logic [ADDR_W-1:0] a);
        emit(a[23:16], 1'b0, 1'b0, WAIT_NONE);
        emit(a[15:8], 1'b0, 1'b0, WAIT_NONE);
        emit(a[7:0], 1'b0, 1'b0, WAIT_NONE);
    endtask

    task automatic close_aai();
        emit_cmd(OP_WRDI);
        emit_cmd(OP_DBSY);
        aai_open = 1'b0;
    endtask

    task automatic consume(input int n);
        wr_addr = wr_addr + ADDR_W'(n);
        wr_left = wr_left - CNT_W'(n);
        if (wr_left == 0)
            wr_active = 1'b0;
    endtask

    task automatic predict_request(input t_flash_req req);
        t_spi_rec r;
        item_frames.delete();
        if (req.kind == REQ_START) begin
            // A new job drops any held byte and leaves word mode first
            if (aai_open)
                close_aai();
            held_valid = 1'b0;
            wr_addr    = req.addr;
            wr_left    = req.count;
            wr_active  = req.count != 0;
        end else if (wr_active) begin
            if (held_valid) begin
                if (!aai_open) begin
                    emit_cmd(OP_EBSY);
                    emit_cmd(OP_WREN);
                    emit(OP_AAI, 1'b1, 1'b0, WAIT_NONE);
                    emit_addr(wr_addr);
                    aai_open = 1'b1;
                end else begin
                    emit(OP_AAI, 1'b1, 1'b0, WAIT_NONE);
                end
                emit(held_byte, 1'b0, 1'b0, WAIT_NONE);
                emit(req.data, 1'b0, 1'b1, WAIT_MISO);
                held_valid = 1'b0;
                consume(2);
                if (wr_left < 2)
                    close_aai();
            end else if (!aai_open && (wr_addr[0] || wr_left < 2)) begin
                emit_cmd(OP_WREN);
                emit(OP_BYTE_PROG, 1'b1, 1'b0, WAIT_NONE);
                emit_addr(wr_addr);
                emit(req.data, 1'b0, 1'b1, WAIT_BUSY);
                consume(1);
            end else begin
                // Hold the first byte of a pair until its partner arrives
                held_byte  = req.data;
                held_valid = 1'b1;
            end
        end
        if (item_frames.size() != 0) begin
            r = item_frames[item_frames.size() - 1];
            r.last_of_item = 1'b1;
            item_frames[item_frames.size() - 1] = r;
        end
        foreach (item_frames[k])
            spi_expect_q.push_back(item_frames[k]);
    endtask

    // Input driver: present the next word once the previous one is taken
    always @(negedge i_clk) begin : drive_in
        bit gap;
        if (send_quiet > 0)
            send_quiet--;
        else if ($urandom_range(0, 63) == 0)
            send_quiet = $urandom_range(8, 40);
        gap = send_quiet == 0 && $urandom_range(0, 99) < send_idle_pct;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (req_q.size() != 0 && !gap) begin
                i_in_valid      <= 1'b1;
                i_req_type      <= req_q[0].kind;
                i_start_address <= req_q[0].addr;
                i_byte_count    <= req_q[0].count;
                i_data_byte     <= req_q[0].data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side back-pressure
    always @(negedge i_clk) begin
        if (recv_quiet > 0)
            recv_quiet--;
        else if ($urandom_range(0, 63) == 0)
            recv_quiet = $urandom_range(8, 40);
        i_out_ready <= recv_quiet != 0 || $urandom_range(0, 99) >= recv_stall_pct;
    end

    // Monitor: predict on accepted requests, check accepted SPI bytes
    always @(posedge i_clk) begin : monitor
        t_spi_rec got;
        t_spi_rec want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                predict_request(req_q.pop_front());
            end
            if (o_out_valid && i_out_ready) begin
                got.spi_byte     = o_spi_byte;
                got.frame_start  = o_frame_start;
                got.frame_end    = o_frame_end;
                got.wait_mark    = o_wait_after;
                got.last_of_item = o_last;
                if (spi_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h fs=%0b fe=%0b w=%0d last=%0b",
                        got.spi_byte, got.frame_start, got.frame_end, got.wait_mark,
                        got.last_of_item));
                end else begin
                    want = spi_expect_q.pop_front();
                    if (got != want)
                        report_mismatch($sformatf({
                            "got %02h fs=%0b fe=%0b w=%0d last=%0b, ",
                            "want %02h fs=%0b fe=%0b w=%0d last=%0b"},
                            got.spi_byte, got.frame_start, got.frame_end, got.wait_mark,
                            got.last_of_item, want.spi_byte, want.frame_start, want.frame_end,
                            want.wait_mark, want.last_of_item));
                end
            end
        end
    end

    task automatic push_start(input logic [ADDR_W-1:0] a, input logic [CNT_W-1:0] n);
        t_flash_req r;
        r.kind  = REQ_START;
        r.addr  = a;
        r.count = n;
        r.data  = BYTE_W'($urandom());
        req_q.push_back(r);
    endtask

    task automatic push_data(input logic [BYTE_W-1:0] d);
        t_flash_req r;
        r.kind  = REQ_DATA;
        r.addr  = ADDR_W'($urandom());
        r.count = CNT_W'($urandom());
        r.data  = d;
        req_q.push_back(r);
    endtask

    // Random jobs: mostly complete, some cut short, some with stray data words
    task automatic queue_random_jobs(input int quota);
        int done;
        int pick;
        int n_data;
        int n_noise;
        logic [ADDR_W-1:0] a;
        logic [CNT_W-1:0]  n;
        done = 0;
        while (done < quota) begin
            pick    = $urandom_range(0, 99);
            n_noise = 0;
            a       = ADDR_W'($urandom());
            if ($urandom_range(0, 7) == 0)
                a = 24'hFFFFF0 | ADDR_W'($urandom_range(0, 15));
            if (pick < 65) begin
                n      = CNT_W'($urandom_range(1, 12));
                n_data = n;
            end else if (pick < 75) begin
                n      = CNT_W'($urandom_range(2, 14));
                n_data = $urandom_range(0, n - 1);
            end else if (pick < 82) begin
                n       = '0;
                n_data  = 0;
                n_noise = $urandom_range(0, 2);
            end else if (pick < 90) begin
                n      = CNT_W'($urandom_range(0, 65535));
                n_data = $urandom_range(1, 8);
            end else begin
                n       = CNT_W'($urandom_range(1, 10));
                n_data  = n;
                n_noise = $urandom_range(1, 3);
            end
            push_start(a, n);
            repeat (n_data + n_noise)
                push_data(BYTE_W'($urandom()));
            done += 1 + n_data;
        end
    endtask

    initial begin
        wr_active  = 1'b0;
        wr_addr    = '0;
        wr_left    = '0;
        held_byte  = '0;
        held_valid = 1'b0;
        aai_open   = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            if (phase == 0) begin
                push_data(8'h5A);                   // no job open: ignored
                push_start(24'h000000, 16'h0000);   // zero-length job
                push_data(8'hFF);
                push_start(24'hFFFFFF, 16'd3);      // odd start, then wrap to 0
                push_data(8'h00);
                push_data(8'hFF);
                push_data(8'h81);
                push_start(24'h000010, 16'd5);      // two pairs, then a leftover byte
                push_data(8'h11);
                push_data(8'h22);
                push_data(8'h33);
                push_data(8'h44);
                push_data(8'h55);
                push_start(24'h123456, 16'hFFFF);   // long job, interrupted below
                push_data(8'hA5);
                push_data(8'h5A);
                push_data(8'hC3);
                push_start(24'hAAAAA9, 16'd4);      // restart with word mode open
                push_data(8'h7E);
                push_data(8'h01);
                push_start(24'h555554, 16'd1);      // drops the held byte
                push_data(8'hFE);
                push_start(24'hFFFFFE, 16'd2);      // pair across the top of memory
                push_data(8'h80);
                push_data(8'h7F);
            end
            queue_random_jobs(120);
            while (req_q.size() != 0 || spi_expect_q.size() != 0)
                @(posedge i_clk);
        end

        repeat (40) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASS spi_flash_write_sequencer_unit");
        else
            $display("FAIL spi_flash_write_sequencer_unit");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL spi_flash_write_sequencer_unit");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sfws_pkg.sv
src/sfws_front.sv
src/sfws_queue.sv
src/sfws_back.sv
src/spi_flash_write_sequencer_unit.sv
tb/spi_flash_write_sequencer_unit_tb.sv
